### design/kcd_pkg.sv
// Shared types and constants of the key chatter detector.
`timescale 1ns / 1ps
`default_nettype none

package kcd_pkg;

    // Raw key number within a half is row * 8 + column, so it spans 32 codes.
    localparam int COLS_PER_ROW  = 8;
    localparam int RAW_KEY_COUNT = 32;
    localparam int RAW_KEY_W     = 5;

    // Per-key word kept in the store: sticky bad mark above an 8-bit age.
    localparam int AGE_W  = 8;
    localparam int WORD_W = AGE_W + 1;
    localparam logic [AGE_W-1:0] AGE_MAX = 8'hFF;

    localparam logic [3:0] LED_OFFSET_LEFT  = 4'd7;
    localparam logic [3:0] LED_OFFSET_RIGHT = 4'd15;

    localparam int QUEUE_DEPTH = 2;

    // Configuration port: one register, selected by address bit 2.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_CHATTER_LIMIT = 1'b0;
    localparam logic [AGE_W-1:0] LIMIT_RESET = 8'd30;

    typedef enum logic [1:0] {
        KIND_IDLE    = 2'd0,
        KIND_PRESS   = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_HELD    = 2'd3
    } kcd_kind_t;

    typedef enum logic [1:0] {
        COLOUR_NONE  = 2'd0,
        COLOUR_GREEN = 2'd1,
        COLOUR_RED   = 2'd2,
        COLOUR_BLUE  = 2'd3
    } kcd_colour_t;

    typedef struct packed {
        kcd_kind_t  kind;
        logic [1:0] led_row;
        logic [3:0] led_column;
    } kcd_cmd_t;

endpackage

`default_nettype wire

### design/kcd_if.sv
// Handshake interfaces for the key item channel and the LED item channel.
`timescale 1ns / 1ps
`default_nettype none

interface kcd_key_if;
    logic       valid;
    logic       ready;
    logic       hand;
    logic [1:0] row;
    logic [2:0] column;
    logic       was_pressed;
    logic       is_pressed;

    modport source (
        output valid, hand, row, column, was_pressed, is_pressed,
        input  ready
    );
    modport sink (
        input  valid, hand, row, column, was_pressed, is_pressed,
        output ready
    );
endinterface

interface kcd_led_if;
    logic       valid;
    logic       ready;
    logic [1:0] led_row;
    logic [3:0] led_column;
    logic [1:0] colour_code;

    modport source (
        output valid, led_row, led_column, colour_code,
        input  ready
    );
    modport sink (
        input  valid, led_row, led_column, colour_code,
        output ready
    );
endinterface

`default_nettype wire

### design/kcd_front.sv
// Front part: accepts key items, classifies them and maps them to a store slot.
`timescale 1ns / 1ps
`default_nettype none

module kcd_front #(
    parameter int KEYS_PER_HAND = 32,
    parameter int NUM_HANDS     = 2,
    parameter int KEY_W         = 5,
    parameter int SLOT_W        = 6
) (
    kcd_key_if.sink             keys,
    input  wire logic           queue_not_full,
    output logic                push,
    output logic [SLOT_W-1:0]   slot,
    output kcd_pkg::kcd_cmd_t   cmd
);
    import kcd_pkg::*;

    logic [KEY_W-1:0]     key_mod_tab [RAW_KEY_COUNT];
    logic [RAW_KEY_W-1:0] raw_key;
    logic [KEY_W-1:0]     key_num;
    logic                 hand_eff;

    // Reduction of the raw key number to the keys of one half, as a constant table.
    for (genvar g = 0; g < RAW_KEY_COUNT; g++) begin : g_key_mod
        assign key_mod_tab[g] = KEY_W'(g % KEYS_PER_HAND);
    end

    assign raw_key  = {keys.row, keys.column};
    assign key_num  = key_mod_tab[raw_key];
    assign hand_eff = (NUM_HANDS > 1) ? keys.hand : 1'b0;

    assign keys.ready = queue_not_full;
    assign push       = keys.valid && queue_not_full;

    always_comb
    begin
        if (hand_eff)
        begin
            slot = SLOT_W'(KEYS_PER_HAND) + SLOT_W'(key_num);
        end
        else
        begin
            slot = SLOT_W'(key_num);
        end

        case ({keys.was_pressed, keys.is_pressed})
            2'b01:   cmd.kind = KIND_PRESS;
            2'b10:   cmd.kind = KIND_RELEASE;
            2'b11:   cmd.kind = KIND_HELD;
            default: cmd.kind = KIND_IDLE;
        endcase

        cmd.led_row = keys.row;
        if (keys.hand)
        begin
            cmd.led_column = LED_OFFSET_RIGHT - {1'b0, keys.column};
        end
        else
        begin
            cmd.led_column = LED_OFFSET_LEFT - {1'b0, keys.column};
        end
    end

endmodule

`default_nettype wire

### design/kcd_queue.sv
// Short first-in first-out queue between the front and the back part.
`timescale 1ns / 1ps
`default_nettype none

module kcd_queue #(
    parameter int W = 14
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    input  wire logic         pop,
    output logic              not_full,
    output logic              not_empty,
    output logic [W-1:0]      head
);
    import kcd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]     entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign not_full  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### design/kcd_back.sv
// Back part: per-key read-modify-write of age and bad mark, and the LED result register.
`timescale 1ns / 1ps
`default_nettype none

module kcd_back #(
    parameter int TOTAL_KEYS = 64,
    parameter int SLOT_W     = 6
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     q_valid,
    input  wire logic [SLOT_W-1:0]        q_slot,
    input  wire kcd_pkg::kcd_cmd_t        q_cmd,
    output logic                          q_pop,
    input  wire logic [kcd_pkg::AGE_W-1:0] limit,
    kcd_led_if.source                     leds
);
    import kcd_pkg::*;

    // Stage 1 holds the item whose store word is being read.
    logic                s1_valid_reg;
    logic [SLOT_W-1:0]   s1_slot_reg;
    kcd_cmd_t            s1_cmd_reg;
    logic [WORD_W-1:0]   rd_word_reg;
    logic                byp_reg;
    logic [WORD_W-1:0]   byp_word_reg;

    logic [WORD_W-1:0]   word_mem_reg [TOTAL_KEYS];
    logic [TOTAL_KEYS-1:0] written_reg;

    logic                out_valid_reg;
    logic [1:0]          out_row_reg;
    logic [3:0]          out_column_reg;
    kcd_colour_t         out_colour_reg;

    logic                out_free;
    logic                s1_fire;
    logic [WORD_W-1:0]   eff_word;
    logic [AGE_W-1:0]    eff_age;
    logic                eff_bad;
    logic [AGE_W-1:0]    age_next;
    logic                bad_next;
    kcd_colour_t         colour_next;

    assign out_free = !out_valid_reg || leds.ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign q_pop    = q_valid && (!s1_valid_reg || s1_fire);

    // A word written in the cycle of its own read comes from the bypass copy;
    // an entry never written reads as zero.
    always_comb
    begin
        if (byp_reg)
        begin
            eff_word = byp_word_reg;
        end
        else if (written_reg[s1_slot_reg])
        begin
            eff_word = rd_word_reg;
        end
        else
        begin
            eff_word = '0;
        end
    end

    assign eff_age = eff_word[AGE_W-1:0];
    assign eff_bad = eff_word[AGE_W];

    always_comb
    begin
        age_next = eff_age;
        bad_next = eff_bad;
        if (s1_cmd_reg.kind == KIND_PRESS)
        begin
            if (eff_age < limit)
            begin
                bad_next = 1'b1;
            end
            age_next = '0;
        end
        else if ((eff_age <= limit) && (eff_age != AGE_MAX))
        begin
            age_next = eff_age + 1'b1;
        end

        if (s1_cmd_reg.kind == KIND_HELD)
        begin
            colour_next = COLOUR_GREEN;
        end
        else if (bad_next)
        begin
            colour_next = COLOUR_RED;
        end
        else if (s1_cmd_reg.kind == KIND_RELEASE)
        begin
            colour_next = COLOUR_BLUE;
        end
        else
        begin
            colour_next = COLOUR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            byp_reg       <= 1'b0;
            written_reg   <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                s1_valid_reg <= 1'b1;
                byp_reg      <= s1_fire && (s1_slot_reg == q_slot);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                out_valid_reg            <= 1'b1;
                written_reg[s1_slot_reg] <= 1'b1;
            end
            else if (leds.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            word_mem_reg[s1_slot_reg] <= {bad_next, age_next};
            out_row_reg               <= s1_cmd_reg.led_row;
            out_column_reg            <= s1_cmd_reg.led_column;
            out_colour_reg            <= colour_next;
        end
        if (q_pop)
        begin
            rd_word_reg  <= word_mem_reg[q_slot];
            byp_word_reg <= {bad_next, age_next};
            s1_slot_reg  <= q_slot;
            s1_cmd_reg   <= q_cmd;
        end
    end

    assign leds.valid       = out_valid_reg;
    assign leds.led_row     = out_row_reg;
    assign leds.led_column  = out_column_reg;
    assign leds.colour_code = out_colour_reg;

`ifndef SYNTHESIS
    a_write_marks_entry: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> written_reg[$past(s1_slot_reg)])
        else $error("store entry not marked written after an update");

    a_bad_is_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && eff_bad |-> bad_next)
        else $error("bad mark cleared by an update");

    a_red_when_bad: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && bad_next && (s1_cmd_reg.kind != KIND_HELD)
        |=> leds.valid && (leds.colour_code == COLOUR_RED))
        else $error("bad key not answered in red");

    a_press_restarts_age: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && (s1_cmd_reg.kind == KIND_PRESS)
        |=> word_mem_reg[$past(s1_slot_reg)][AGE_W-1:0] == '0)
        else $error("press did not restart the key age");
`endif

endmodule

`default_nettype wire

### design/key_chatter_detector_unit.sv
// Top level of the key chatter detector: configuration register and part wiring.
//
//   channel   dir   handshake            payload
//   keys      in    valid/ready          hand, row, column, was_pressed, is_pressed
//   leds      out   valid/ready          led_row, led_column, colour_code
//   apb       in    psel/penable/pready  paddr, pwdata, prdata (chatter_limit)
//
// One item is accepted per cycle while the queue has room; each item reads and
// rewrites its per-key store entry in stage one of the back part, so throughput
// is one item per cycle while the LED side takes results without stalling.
// Reset clears the written marks of all store entries at once, so every key
// starts with zero age and no bad mark, and no clearing pass is needed.
// A stall on the LED side fills the output register, then stage one, then the
// two-entry queue, after which the key side sees ready low.
`timescale 1ns / 1ps
`default_nettype none

module key_chatter_detector_unit #(
    parameter int KEYS_PER_HAND = 32,
    parameter int NUM_HANDS     = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    kcd_key_if.sink          keys,
    kcd_led_if.source        leds,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import kcd_pkg::*;

    // Store size and index widths follow from the key count per half and
    // the number of halves.
    localparam int TOTAL_KEYS = KEYS_PER_HAND * NUM_HANDS;
    localparam int KEY_W      = (KEYS_PER_HAND > 1) ? $clog2(KEYS_PER_HAND) : 1;
    localparam int SLOT_W     = (TOTAL_KEYS > 1) ? $clog2(TOTAL_KEYS) : 1;
    localparam int Q_W        = SLOT_W + $bits(kcd_cmd_t);

    logic [AGE_W-1:0]  limit_reg;
    logic              cfg_write;

    logic              push;
    logic [SLOT_W-1:0] front_slot;
    kcd_cmd_t          front_cmd;
    logic              q_not_full;
    logic              q_not_empty;
    logic              q_pop;
    logic [Q_W-1:0]    q_head;
    logic [SLOT_W-1:0] q_slot;
    kcd_cmd_t          q_cmd;

    // The register port has no wait states; a write lands in the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[PADDR_W-1] == REG_CHATTER_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            limit_reg <= pwdata[AGE_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[PADDR_W-1] == REG_CHATTER_LIMIT)
        begin
            prdata = {{(PDATA_W - AGE_W){1'b0}}, limit_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // The front part classifies each key item and writes it into the queue.
    kcd_front #(
        .KEYS_PER_HAND (KEYS_PER_HAND),
        .NUM_HANDS     (NUM_HANDS),
        .KEY_W         (KEY_W),
        .SLOT_W        (SLOT_W)
    ) u_front (
        .keys           (keys),
        .queue_not_full (q_not_full),
        .push           (push),
        .slot           (front_slot),
        .cmd            (front_cmd)
    );

    kcd_queue #(
        .W (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({front_slot, front_cmd}),
        .pop       (q_pop),
        .not_full  (q_not_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    assign q_slot = q_head[Q_W-1 -: SLOT_W];
    assign q_cmd  = kcd_cmd_t'(q_head[$bits(kcd_cmd_t)-1:0]);

    // The back part owns the per-key store and the result register.
    kcd_back #(
        .TOTAL_KEYS (TOTAL_KEYS),
        .SLOT_W     (SLOT_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_not_empty),
        .q_slot  (q_slot),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .limit   (limit_reg),
        .leds    (leds)
    );

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for the key chatter detector unit.
`timescale 1ns / 1ps

module tb_top;
    import kcd_pkg::*;

    // Sizes of the instance under test; the store holds one entry per key.
    localparam int KEYS_PER_HAND = 32;
    localparam int NUM_HANDS     = 2;
    localparam int TOTAL_KEYS    = KEYS_PER_HAND * NUM_HANDS;

    // The chatter limit is the only register; it sits at byte address zero.
    localparam logic [PADDR_W-1:0] LIMIT_ADDR = {REG_CHATTER_LIMIT, 2'b00};

    typedef struct {
        logic       hand;
        logic [1:0] row;
        logic [2:0] column;
        logic       was_pressed;
        logic       is_pressed;
    } key_scan_t;

    typedef struct {
        logic [1:0]  led_row;
        logic [3:0]  led_column;
        kcd_colour_t colour;
    } led_answer_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    kcd_key_if keys_if ();
    kcd_led_if leds_if ();

    key_chatter_detector_unit #(
        .KEYS_PER_HAND(KEYS_PER_HAND),
        .NUM_HANDS    (NUM_HANDS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .keys   (keys_if),
        .leds   (leds_if),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // Our own copy of the per-key state and of the limit register. The state
    // is updated as each key item is accepted, in the order the block sees it.
    logic [AGE_W-1:0] key_age [TOTAL_KEYS];
    logic             key_bad [TOTAL_KEYS];
    logic [AGE_W-1:0] limit_now;

    key_scan_t   scan_queue[$];    // key items waiting to be driven
    led_answer_t answer_queue[$];  // LED answers predicted but not yet seen

    int  error_count   = 0;
    int  queued_items  = 0;
    int  keys_accepted = 0;
    int  answers_seen  = 0;
    int  limit_writes  = 0;
    int  colour_count [4];

    logic key_taken = 1'b0;
    int   src_gap   = 0;
    int   src_calm  = 0;
    int   sink_stall = 0;
    int   sink_calm  = 0;

    // Free-running clock, 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Computes the LED answer of one key item and advances that key's age
    // counter and bad mark. A fresh press that comes while the age is still
    // below the limit marks the key bad for good; any other item ages the
    // key, stopping one past the limit and never going beyond 255.
    function automatic led_answer_t predict_answer(key_scan_t k);
        int unsigned slot;
        led_answer_t a;
        slot = (k.hand % NUM_HANDS) * KEYS_PER_HAND
             + ((k.row * COLS_PER_ROW + k.column) % KEYS_PER_HAND);
        if (!k.was_pressed && k.is_pressed)
        begin
            if (key_age[slot] < limit_now)
                key_bad[slot] = 1'b1;
            key_age[slot] = '0;
        end
        else if (key_age[slot] <= limit_now && key_age[slot] != AGE_MAX)
        begin
            key_age[slot] = key_age[slot] + 1'b1;
        end
        // The LED strip runs mirrored, so the column counts down from the offset.
        a.led_row    = k.row;
        a.led_column = (k.hand ? LED_OFFSET_RIGHT : LED_OFFSET_LEFT) - {1'b0, k.column};
        // Held beats bad, bad beats released.
        if (k.was_pressed && k.is_pressed)
            a.colour = COLOUR_GREEN;
        else if (key_bad[slot])
            a.colour = COLOUR_RED;
        else if (k.was_pressed)
            a.colour = COLOUR_BLUE;
        else
            a.colour = COLOUR_NONE;
        return a;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Key side driver. Inputs change on the falling edge; an item stays on the
    // bus until the rising edge that accepts it. Every so often a calm stretch
    // sends items back to back with no gaps at all.
    always @(negedge clk)
    begin
        key_scan_t next_scan;
        if (!rst_n)
        begin
            keys_if.valid       <= 1'b0;
            keys_if.hand        <= 1'b0;
            keys_if.row         <= '0;
            keys_if.column      <= '0;
            keys_if.was_pressed <= 1'b0;
            keys_if.is_pressed  <= 1'b0;
        end
        else if (keys_if.valid && !key_taken)
        begin
            // Still waiting for the block to take the current item.
        end
        else if (src_gap > 0)
        begin
            src_gap--;
            keys_if.valid <= 1'b0;
        end
        else if (scan_queue.size() != 0)
        begin
            next_scan = scan_queue.pop_front();
            keys_if.valid       <= 1'b1;
            keys_if.hand        <= next_scan.hand;
            keys_if.row         <= next_scan.row;
            keys_if.column      <= next_scan.column;
            keys_if.was_pressed <= next_scan.was_pressed;
            keys_if.is_pressed  <= next_scan.is_pressed;
            if (src_calm > 0)
            begin
                src_calm--;
                src_gap = 0;
            end
            else
            begin
                src_gap = draw_gap();
                if ($urandom_range(0, 39) == 0)
                    src_calm = $urandom_range(20, 80);
            end
        end
        else
        begin
            keys_if.valid <= 1'b0;
        end
    end

    // LED side: ready drops for stalls of random length, with calm stretches
    // in which it stays high throughout.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            leds_if.ready <= 1'b0;
        end
        else if (sink_stall > 0)
        begin
            sink_stall--;
            leds_if.ready <= 1'b0;
        end
        else
        begin
            leds_if.ready <= 1'b1;
            if (sink_calm > 0)
                sink_calm--;
            else
            begin
                sink_stall = draw_gap();
                if ($urandom_range(0, 39) == 0)
                    sink_calm = $urandom_range(20, 80);
            end
        end
    end

    // Monitor on the rising edge: each accepted key item yields one predicted
    // answer, and each accepted LED item is checked against the oldest one.
    always @(posedge clk)
    begin
        key_scan_t   seen;
        led_answer_t want;
        key_taken <= rst_n && keys_if.valid && keys_if.ready;
        if (rst_n)
        begin
            if (keys_if.valid && keys_if.ready)
            begin
                seen.hand        = keys_if.hand;
                seen.row         = keys_if.row;
                seen.column      = keys_if.column;
                seen.was_pressed = keys_if.was_pressed;
                seen.is_pressed  = keys_if.is_pressed;
                answer_queue.push_back(predict_answer(seen));
                keys_accepted++;
            end
            if (leds_if.valid && leds_if.ready)
            begin
                answers_seen++;
                if (answer_queue.size() == 0)
                begin
                    $error("LED item with no answer pending: row %0d column %0d colour %0d",
                           leds_if.led_row, leds_if.led_column, leds_if.colour_code);
                    error_count++;
                end
                else
                begin
                    want = answer_queue.pop_front();
                    colour_count[want.colour]++;
                    if (leds_if.led_row !== want.led_row)
                    begin
                        $error("led_row: expected %0d, got %0d", want.led_row, leds_if.led_row);
                        error_count++;
                    end
                    if (leds_if.led_column !== want.led_column)
                    begin
                        $error("led_column: expected %0d, got %0d",
                               want.led_column, leds_if.led_column);
                        error_count++;
                    end
                    if (leds_if.colour_code !== want.colour)
                    begin
                        $error("colour_code: expected %0d (%s), got %0d",
                               want.colour, want.colour.name(), leds_if.colour_code);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic push_scan(input logic hand, input logic [1:0] row, input logic [2:0] column,
                             input logic was_pressed, input logic now_pressed);
        key_scan_t k;
        k.hand        = hand;
        k.row         = row;
        k.column      = column;
        k.was_pressed = was_pressed;
        k.is_pressed  = now_pressed;
        scan_queue.push_back(k);
        queued_items++;
    endtask

    // A key item with every field at random, including out-of-order bit pairs.
    task automatic push_noise();
        push_scan(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                  3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    endtask

    // One item of a key's life, sometimes preceded by a stray item elsewhere.
    task automatic push_life_step(input key_scan_t k, input logic was_pressed,
                                  input logic now_pressed);
        if ($urandom_range(0, 5) == 0)
            push_noise();
        push_scan(k.hand, k.row, k.column, was_pressed, now_pressed);
    endtask

    // A well-formed life of one key: a few press, hold, release, rest rounds.
    // The number of scans between presses is aimed mostly at the chatter
    // boundary, so both sides of the limit and the age ceiling get hit.
    task automatic queue_key_life();
        key_scan_t k;
        int        rounds;
        int        span;
        int        held;
        k.hand   = 1'($urandom_range(0, 1));
        k.row    = 2'($urandom_range(0, 3));
        k.column = 3'($urandom_range(0, 7));
        rounds   = int'($urandom_range(1, 4));
        repeat (rounds)
        begin
            if (limit_now <= 40 && $urandom_range(0, 2) != 0)
                span = int'(limit_now) + int'($urandom_range(0, 3)) - 1;
            else
                span = int'($urandom_range(1, 8));
            if (span < 1)
                span = 1;
            held = int'($urandom_range(0, span - 1));
            push_life_step(k, 1'b0, 1'b1);
            repeat (held)
                push_life_step(k, 1'b1, 1'b1);
            push_life_step(k, 1'b1, 1'b0);
            repeat (span - 1 - held)
                push_life_step(k, 1'b0, 1'b0);
        end
        if ($urandom_range(0, 4) == 0)
            push_noise();
    endtask

    task automatic queue_random(input int count);
        int target;
        target = queued_items + count;
        while (queued_items < target)
            queue_key_life();
    endtask

    // Waits until every key item has gone in and every answer has come out,
    // then a few cycles more so the block is truly quiet.
    task automatic wait_idle();
        while (scan_queue.size() != 0 || keys_if.valid || answer_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle; the register takes the value
    // on the rising edge of the access cycle.
    task automatic write_limit(input logic [AGE_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = LIMIT_ADDR;
        pwdata  = {{(PDATA_W - AGE_W){1'b0}}, value};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        limit_now = value;
        limit_writes++;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Stimulus and phase control.
    initial
    begin
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        keys_if.valid       = 1'b0;
        keys_if.hand        = 1'b0;
        keys_if.row         = '0;
        keys_if.column      = '0;
        keys_if.was_pressed = 1'b0;
        keys_if.is_pressed  = 1'b0;
        leds_if.ready       = 1'b0;
        for (int i = 0; i < TOTAL_KEYS; i++)
        begin
            key_age[i] = '0;
            key_bad[i] = 1'b0;
        end
        for (int i = 0; i < 4; i++)
            colour_count[i] = 0;
        limit_now = LIMIT_RESET;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed items at the reset limit. A fresh key has age zero, so its
        // very first press already counts as chatter.
        push_scan(1'b0, 2'd0, 3'd0, 1'b0, 1'b0);  // idle, leftmost LED column 7
        push_scan(1'b0, 2'd0, 3'd0, 1'b0, 1'b1);  // early press marks the key bad
        push_scan(1'b0, 2'd0, 3'd0, 1'b1, 1'b1);  // held wins over bad
        push_scan(1'b0, 2'd0, 3'd0, 1'b1, 1'b0);  // release of a bad key stays red
        push_scan(1'b1, 2'd3, 3'd7, 1'b0, 1'b0);  // right half, LED column 8
        push_scan(1'b1, 2'd3, 3'd7, 1'b1, 1'b0);  // clean release shows blue
        push_scan(1'b1, 2'd3, 3'd7, 1'b1, 1'b1);
        push_scan(1'b1, 2'd3, 3'd7, 1'b0, 1'b1);  // quick repress is chatter
        push_scan(1'b1, 2'd3, 3'd7, 1'b0, 1'b0);  // bad mark sticks while idle
        push_scan(1'b0, 2'd3, 3'd7, 1'b1, 1'b0);  // left half, LED column 0
        push_scan(1'b1, 2'd0, 3'd0, 1'b0, 1'b0);  // right half, LED column 15
        push_scan(1'b0, 2'd2, 3'd5, 1'b1, 1'b1);
        push_scan(1'b1, 2'd1, 3'd2, 1'b0, 1'b1);
        push_scan(1'b0, 2'd1, 3'd2, 1'b1, 1'b0);
        push_scan(1'b1, 2'd2, 3'd5, 1'b1, 1'b0);
        push_scan(1'b0, 2'd0, 3'd7, 1'b0, 1'b0);
        push_scan(1'b1, 2'd3, 3'd0, 1'b1, 1'b1);
        wait_idle();

        // Widest limit. One key that the directed items never touched idles
        // long enough for its age to reach the 255 ceiling; a press then is
        // not chatter, so its release still shows blue.
        write_limit(8'd255);
        repeat (260)
            push_scan(1'b1, 2'd1, 3'd3, 1'b0, 1'b0);
        push_scan(1'b1, 2'd1, 3'd3, 1'b0, 1'b1);
        push_scan(1'b1, 2'd1, 3'd3, 1'b1, 1'b0);
        queue_random(10);
        wait_idle();

        // A zero limit can never flag chatter; ages stop at one.
        write_limit(8'd0);
        queue_random(20);
        wait_idle();

        // A tiny limit puts every random press close to the boundary.
        write_limit(8'd3);
        queue_random(25);
        wait_idle();

        write_limit(8'd254);
        queue_random(20);
        wait_idle();

        write_limit(8'($urandom_range(1, 40)));
        queue_random(20);
        wait_idle();

        // Anything arriving now has no answer waiting and is flagged.
        repeat (8) @(posedge clk);
        if (answer_queue.size() != 0)
        begin
            $error("%0d LED answers never arrived", answer_queue.size());
            error_count++;
        end

        $display("Drove %0d key items under %0d chatter limit settings; checked %0d LED items.",
                 keys_accepted, limit_writes + 1, answers_seen);
        $display("Colours seen: none %0d, green %0d, red %0d, blue %0d.",
                 colour_count[COLOUR_NONE], colour_count[COLOUR_GREEN],
                 colour_count[COLOUR_RED], colour_count[COLOUR_BLUE]);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run with every gap and stall long.
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
